// ===== hdl/prrs_pkg.sv =====
// shared types and constants for the priority round-robin scheduler
// no dependencies
package prrs_pkg;
	localparam int MAX_THREADS_DEF  = 64;
	localparam int MAX_PRIORITY_DEF = 5;
	localparam int MAX_DEVICES_DEF  = 256;

	localparam logic [2:0] OP_FORK   = 3'd0;
	localparam logic [2:0] OP_WAIT   = 3'd1;
	localparam logic [2:0] OP_SIGNAL = 3'd2;
	localparam logic [2:0] OP_EXEC   = 3'd3;
	localparam logic [2:0] OP_FINISH = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_INV  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] TS_IDLE  = 2'd0;
	localparam logic [1:0] TS_READY = 2'd1;
	localparam logic [1:0] TS_RUN   = 2'd2;
	localparam logic [1:0] TS_WAIT  = 2'd3;

	localparam logic [0:0] CFG_QUANTUM = 1'd0;
	localparam logic [0:0] CFG_DEVICES = 1'd1;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] new_priority;
		logic [7:0] device;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] value;
		logic [5:0] running_thread;
		logic       running_valid;
	} rsp_t;
endpackage

// ===== hdl/prrs_if.sv =====
// valid/ready channel carrying one payload beat
// depends on nothing; payload type is a parameter
interface prrs_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/priority_round_robin_scheduler_top.sv =====
// priority round-robin scheduler: one event in, one result beat out
// accepted events make one walk over the forked slots
// rejected events skip the walk and go straight to the output step
// signal events walk twice (wake, then pick)
// throughput: one event at a time; the next is taken the cycle after the result beat leaves
// reset (arst_n low, async) clears the thread table status, counters and output beat
// depends on prrs_pkg and prrs_if
module priority_round_robin_scheduler_top
	import prrs_pkg::*;
#(
	parameter int MAX_THREADS  = MAX_THREADS_DEF,
	parameter int MAX_PRIORITY = MAX_PRIORITY_DEF,
	parameter int MAX_DEVICES  = MAX_DEVICES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	prrs_if.sink       req,
	prrs_if.source     rsp,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int IW = $clog2(MAX_THREADS);
	localparam int CW = $clog2(MAX_THREADS + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WAKE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_SCHD = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	req_t req_q;
	rsp_t out_q;
	logic out_valid_q;

	// configuration
	logic [15:0] quantum_q;
	logic [8:0]  devcnt_q;

	// thread table
	logic [2:0]  prio_q  [MAX_THREADS];
	logic [1:0]  tstat_q [MAX_THREADS];
	logic [7:0]  wdev_q  [MAX_THREADS];
	logic [31:0] stamp_q [MAX_THREADS];

	logic [CW-1:0] total_q;
	logic [IW-1:0] cur_q;
	logic [15:0]   ticks_q;
	logic [31:0]   stampc_q;
	logic          run_q;

	// walk registers
	logic [CW-1:0] idx_q;
	logic          best_v_q;
	logic [IW-1:0] best_q;
	logic [2:0]    best_p_q;
	logic [31:0]   best_s_q;
	logic [6:0]    woken_q;

	// registered table reads, landing in the cycle after the walk address
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [2:0]    rd_prio_s1;
	logic [31:0]   rd_stamp_s1;
	logic [7:0]    rd_dev_s1;
	logic [2:0]    cur_p_s1;

	logic [IW-1:0] idx_w;
	logic [8:0]    dev_lim;
	logic          dev_bad;
	logic          better;
	logic          preempt;

	assign idx_w   = idx_q[IW-1:0];
	assign dev_lim = (devcnt_q > 9'(MAX_DEVICES)) ? 9'(MAX_DEVICES) : devcnt_q;
	assign dev_bad = {1'b0, req.data.device} >= dev_lim;
	// the one comparator: candidate vs best so far
	assign better  = !best_v_q || (rd_prio_s1 > best_p_q) ||
		(rd_prio_s1 == best_p_q && rd_stamp_s1 < best_s_q);
	assign preempt = best_v_q && ((best_p_q > cur_p_s1) ||
		(best_p_q == cur_p_s1 && ticks_q == 16'd0));

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= 16'd1;
			devcnt_q  <= 9'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QUANTUM: quantum_q <= cfg_data;
				CFG_DEVICES: devcnt_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// payload tables carry no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid && req.ready && req.data.operation == OP_FORK
			&& req.data.new_priority <= 3'(MAX_PRIORITY) && total_q < CW'(MAX_THREADS)) begin
			prio_q[total_q[IW-1:0]]  <= req.data.new_priority;
			wdev_q[total_q[IW-1:0]]  <= 8'd0;
			stamp_q[total_q[IW-1:0]] <= stampc_q;
		end
		if (state_q == S_IDLE && req.valid && req.ready && req.data.operation == OP_WAIT
			&& run_q) begin
			wdev_q[cur_q] <= req.data.device;
		end
		if (state_q == S_SCHD && run_q && preempt)
			stamp_q[cur_q] <= stampc_q;
		rd_idx_s1   <= idx_w;
		rd_prio_s1  <= prio_q[idx_w];
		rd_stamp_s1 <= stamp_q[idx_w];
		rd_dev_s1   <= wdev_q[idx_w];
		// running thread priority, stable long before the schedule step
		cur_p_s1    <= prio_q[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			req_q       <= '0;
			total_q     <= '0;
			cur_q       <= '0;
			ticks_q     <= '0;
			stampc_q    <= '0;
			run_q       <= 1'b0;
			idx_q       <= '0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			best_p_q    <= '0;
			best_s_q    <= '0;
			woken_q     <= '0;
			rd_v_s1     <= 1'b0;
			for (int i = 0; i < MAX_THREADS; i++) tstat_q[i] <= TS_IDLE;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			// a slot address goes out while the walk has slots left
			rd_v_s1 <= ((state_q == S_WAKE) || (state_q == S_SCAN)) && (idx_q < total_q);
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q    <= req.data;
						idx_q    <= '0;
						best_v_q <= 1'b0;
						woken_q  <= '0;
						out_q.status <= ST_OK;
						out_q.value  <= '0;
						state_q  <= S_SCAN;
						unique case (req.data.operation) inside
							OP_FORK: begin
								if (req.data.new_priority > 3'(MAX_PRIORITY)) begin
									out_q.status <= ST_INV;
									state_q <= S_OUT;
								end else if (total_q >= CW'(MAX_THREADS)) begin
									out_q.status <= ST_FULL;
									state_q <= S_OUT;
								end else begin
									tstat_q[total_q[IW-1:0]] <= TS_READY;
									stampc_q <= stampc_q + 32'd1;
									total_q  <= total_q + 1'b1;
									out_q.value <= 7'(total_q);
									if (run_q && ticks_q != 16'd0) ticks_q <= ticks_q - 16'd1;
								end
							end
							OP_WAIT, OP_SIGNAL: begin
								if (dev_bad || (req.data.operation == OP_WAIT && !run_q)) begin
									out_q.status <= ST_INV;
									state_q <= S_OUT;
								end else if (req.data.operation == OP_WAIT) begin
									tstat_q[cur_q] <= TS_WAIT;
									run_q <= 1'b0;
								end else begin
									state_q <= S_WAKE;
								end
							end
							OP_EXEC: begin
								if (run_q && ticks_q != 16'd0) ticks_q <= ticks_q - 16'd1;
							end
							OP_FINISH: begin
								if (!run_q) begin
									out_q.status <= ST_INV;
									state_q <= S_OUT;
								end else begin
									tstat_q[cur_q] <= TS_IDLE;
									run_q <= 1'b0;
								end
							end
							default: begin
								out_q.status <= ST_INV;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_WAKE: begin
					// one slot a cycle: wake waiters on the device
					if (idx_q < total_q)
						idx_q <= idx_q + 1'b1;
					if (rd_v_s1 && tstat_q[rd_idx_s1] == TS_WAIT && rd_dev_s1 == req_q.device) begin
						tstat_q[rd_idx_s1] <= TS_READY;
						woken_q <= woken_q + 7'd1;
					end
					// last slot data has landed once no read is pending
					if (idx_q >= total_q && !rd_v_s1) begin
						idx_q   <= '0;
						out_q.value <= woken_q;
						if (run_q && ticks_q != 16'd0) ticks_q <= ticks_q - 16'd1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one slot a cycle: best ready thread, compared on the registered read
					if (idx_q < total_q)
						idx_q <= idx_q + 1'b1;
					else
						state_q <= S_SCHD;
					if (rd_v_s1 && tstat_q[rd_idx_s1] == TS_READY && better) begin
						best_v_q <= 1'b1;
						best_q   <= rd_idx_s1;
						best_p_q <= rd_prio_s1;
						best_s_q <= rd_stamp_s1;
					end
				end
				S_SCHD: begin
					if (!run_q) begin
						if (best_v_q) begin
							tstat_q[best_q] <= TS_RUN;
							cur_q   <= best_q;
							run_q   <= 1'b1;
							ticks_q <= quantum_q;
						end
					end else if (preempt) begin
						tstat_q[cur_q]  <= TS_READY;
						stampc_q        <= stampc_q + 32'd1;
						tstat_q[best_q] <= TS_RUN;
						cur_q   <= best_q;
						ticks_q <= quantum_q;
					end else if (ticks_q == 16'd0) begin
						ticks_q <= quantum_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_q.running_thread <= run_q ? 6'(cur_q) : 6'd0;
					out_q.running_valid  <= run_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/prrs_checker.sv =====
// scoreboard for the priority round-robin scheduler: tracks config writes,
// predicts one result per accepted event and compares every result beat
// depends on prrs_pkg
module prrs_checker
	import prrs_pkg::*;
#(
	parameter int MAX_THREADS  = MAX_THREADS_DEF,
	parameter int MAX_PRIORITY = MAX_PRIORITY_DEF,
	parameter int MAX_DEVICES  = MAX_DEVICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  req_t        req_data,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  rsp_t        rsp_data,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          backlog,
	output int          fail_count
);
	logic [2:0]  thr_prio   [MAX_THREADS];
	logic [1:0]  thr_state  [MAX_THREADS];
	logic [7:0]  thr_dev    [MAX_THREADS];
	logic [31:0] thr_stamp  [MAX_THREADS];
	int          thr_total;
	logic [5:0]  cur_thread;
	logic [15:0] ticks_left;
	logic [31:0] stamp_ctr;
	logic        running;
	logic [15:0] quantum;
	logic [8:0]  dev_count;
	rsp_t        expected_q[$];

	task automatic launch(input int id);
		thr_state[id] = TS_RUN;
		cur_thread = id[5:0];
		running = 1'b1;
		ticks_left = quantum;
	endtask

	task automatic burn_tick();
		if (running && ticks_left != 0)
			ticks_left = ticks_left - 16'd1;
	endtask

	// pick best ready thread, then preempt, rotate or reload the quantum
	task automatic reschedule();
		int best;
		int cur;
		best = -1;
		cur = cur_thread;
		for (int i = 0; i < thr_total; i++) begin
			if (thr_state[i] != TS_READY)
				continue;
			if (best < 0 || thr_prio[i] > thr_prio[best] ||
			    (thr_prio[i] == thr_prio[best] && thr_stamp[i] < thr_stamp[best]))
				best = i;
		end
		if (!running) begin
			if (best >= 0)
				launch(best);
			return;
		end
		if (best >= 0 && (thr_prio[best] > thr_prio[cur] ||
		    (thr_prio[best] == thr_prio[cur] && ticks_left == 0))) begin
			thr_state[cur] = TS_READY;
			thr_stamp[cur] = stamp_ctr;
			stamp_ctr = stamp_ctr + 1;
			launch(best);
			return;
		end
		if (ticks_left == 0)
			ticks_left = quantum;
	endtask

	task automatic predict_event(input req_t ev, output rsp_t res);
		int limit;
		int woken;
		limit = (dev_count > MAX_DEVICES) ? MAX_DEVICES : dev_count;
		res = '0;
		woken = 0;
		case (ev.operation)
			OP_FORK: begin
				if (ev.new_priority > MAX_PRIORITY)
					res.status = ST_INV;
				else if (thr_total >= MAX_THREADS)
					res.status = ST_FULL;
				else begin
					thr_prio[thr_total] = ev.new_priority;
					thr_state[thr_total] = TS_READY;
					thr_dev[thr_total] = '0;
					thr_stamp[thr_total] = stamp_ctr;
					stamp_ctr = stamp_ctr + 1;
					res.value = thr_total[6:0];
					thr_total++;
					burn_tick();
					reschedule();
				end
			end
			OP_WAIT: begin
				if (ev.device >= limit || !running)
					res.status = ST_INV;
				else begin
					thr_state[cur_thread] = TS_WAIT;
					thr_dev[cur_thread] = ev.device;
					running = 1'b0;
					reschedule();
				end
			end
			OP_SIGNAL: begin
				if (ev.device >= limit)
					res.status = ST_INV;
				else begin
					for (int i = 0; i < thr_total; i++)
						if (thr_state[i] == TS_WAIT && thr_dev[i] == ev.device) begin
							thr_state[i] = TS_READY;
							woken++;
						end
					res.value = woken[6:0];
					burn_tick();
					reschedule();
				end
			end
			OP_EXEC: begin
				burn_tick();
				reschedule();
			end
			OP_FINISH: begin
				if (!running)
					res.status = ST_INV;
				else begin
					thr_state[cur_thread] = TS_IDLE;
					running = 1'b0;
					reschedule();
				end
			end
			default: res.status = ST_INV;
		endcase
		res.running_thread = running ? cur_thread : '0;
		res.running_valid = running;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++)
				thr_state[i] = TS_IDLE;
			thr_total = 0;
			cur_thread = '0;
			ticks_left = '0;
			stamp_ctr = '0;
			running = 1'b0;
			quantum = 16'd1;
			dev_count = '0;
			fail_count = 0;
			expected_q.delete();
			backlog = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_QUANTUM)
					quantum = cfg_data;
				else
					dev_count = cfg_data[8:0];
			end
			if (rsp_valid && rsp_ready) begin
				got = rsp_data;
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected: %p", got);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, got.value);
						fail_count++;
					end
					if (got.running_thread !== want.running_thread) begin
						$error("running_thread: expected %0d, got %0d",
							want.running_thread, got.running_thread);
						fail_count++;
					end
					if (got.running_valid !== want.running_valid) begin
						$error("running_valid: expected %0d, got %0d",
							want.running_valid, got.running_valid);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				predict_event(req_data, want);
				expected_q.push_back(want);
			end
			backlog = expected_q.size();
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// top of the scheduler testbench: clock, reset, event stimulus, result sink
// and verdict; depends on prrs_pkg, prrs_if, prrs_checker and the block
module tb_top;
	import prrs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;
	int          backlog;
	int          fail_count;
	bit          steady;     // no idling on either side for this phase
	bit          hold_off;   // ask the sink for one long stall
	int          dev_limit;  // valid device count as the block sees it

	prrs_if #(.payload_t(req_t)) req_ch (clk);
	prrs_if #(.payload_t(rsp_t)) rsp_ch (clk);

	priority_round_robin_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	prrs_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_data   (req_ch.data),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_data   (rsp_ch.data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.backlog    (backlog),
		.fail_count (fail_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// hard stop in case the block hangs
	initial begin
		#(12 * 1500000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic req_t make_event(logic [2:0] op, logic [2:0] prio, logic [7:0] dev);
		req_t ev;
		ev.operation = op;
		ev.new_priority = prio;
		ev.device = dev;
		return ev;
	endfunction

	// one beat into the block, with a random gap in front unless steady
	task automatic send_event(input req_t ev);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.data <= ev;
		req_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// both registers are written back to back; block must be idle
	task automatic write_config(input logic [15:0] quantum, input logic [15:0] devices);
		cfg_we <= 1'b1;
		cfg_index <= CFG_QUANTUM;
		cfg_data <= quantum;
		@(posedge clk);
		cfg_index <= CFG_DEVICES;
		cfg_data <= devices;
		@(posedge clk);
		cfg_we <= 1'b0;
		dev_limit = (devices[8:0] > 256) ? 256 : devices[8:0];
	endtask

	// drop the request valid and let every expected result drain, with spare idle time after
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (backlog != 0);
		repeat (8) @(posedge clk);
	endtask

	// mostly well-formed events on valid devices, some noise
	function automatic req_t random_event();
		int pick;
		logic [2:0] op;
		logic [2:0] prio;
		logic [7:0] dev;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			op = OP_FORK;
		else if (pick < 28)
			op = OP_WAIT;
		else if (pick < 50)
			op = OP_SIGNAL;
		else if (pick < 92)
			op = OP_EXEC;
		else if (pick < 96)
			op = OP_FINISH;
		else
			op = 3'($urandom_range(5, 7));
		prio = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
		if (dev_limit == 0 || $urandom_range(0, 9) == 0)
			dev = 8'($urandom_range(0, 255));
		else
			dev = 8'($urandom_range(0, dev_limit - 1));
		return make_event(op, prio, dev);
	endfunction

	// result sink: random stalls, and once one very long one so the block backs up
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				stall = 600;
			end else
				stall = steady ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
		end
	end

	initial begin
		logic [15:0] quanta [8] = '{16'd3, 16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd7, 16'd1, 16'd4};
		logic [15:0] devs   [8] = '{16'd4, 16'h01FF, 16'd1, 16'd256, 16'd8, 16'd2, 16'd3, 16'd16};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		steady = 1'b0;
		hold_off = 1'b0;
		dev_limit = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: quantum 1, no devices; idle corner cases first
		send_event(make_event(OP_EXEC, 3'd0, 8'd0));
		send_event(make_event(OP_WAIT, 3'd0, 8'd0));    // nobody running
		send_event(make_event(OP_FINISH, 3'd0, 8'd0));  // nobody running
		send_event(make_event(3'd5, 3'd0, 8'd0));       // unknown opcodes
		send_event(make_event(3'd7, 3'd7, 8'hFF));
		send_event(make_event(OP_FORK, 3'd7, 8'd0));    // priority too high
		send_event(make_event(OP_FORK, 3'd6, 8'd0));
		send_event(make_event(OP_SIGNAL, 3'd0, 8'd0));  // no valid devices
		send_event(make_event(OP_FORK, 3'd0, 8'd0));
		send_event(make_event(OP_FORK, 3'd5, 8'd0));    // preempts
		send_event(make_event(OP_EXEC, 3'd0, 8'd0));
		send_event(make_event(OP_WAIT, 3'd0, 8'd0));    // bad device
		drain();

		// zero quantum and the full device range
		write_config(16'd0, 16'd256);
		send_event(make_event(OP_FORK, 3'd5, 8'd0));
		send_event(make_event(OP_EXEC, 3'd0, 8'd0));
		send_event(make_event(OP_WAIT, 3'd0, 8'hFF));
		send_event(make_event(OP_SIGNAL, 3'd0, 8'hFF)); // wakes the waiter
		send_event(make_event(OP_SIGNAL, 3'd0, 8'd0));  // wakes nobody
		send_event(make_event(OP_EXEC, 3'd0, 8'd0));
		send_event(make_event(OP_FINISH, 3'd0, 8'd0));
		send_event(make_event(OP_EXEC, 3'd0, 8'd0));
		drain();

		// random phases, each with its own quantum and device count;
		// forks eventually fill the table and then get the full status
		for (int p = 0; p < 8; p++) begin
			write_config(quanta[p], devs[p]);
			steady = ($urandom_range(0, 3) == 0);
			if (p == 3)
				hold_off = 1'b1;
			for (int n = 0; n < 140; n++)
				send_event(random_event());
			drain();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
